@@ design/rlef_pkg.sv @@
// Shared constants, codes and types of the rate-limited event FIFO.
`default_nettype none
package rlef_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int EVENT_WIDTH = 32;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int MAX_TAKE    = 16;
    localparam int TAKE_W      = 5;
    localparam int CMP_W       = (CNT_W > TAKE_W) ? CNT_W : TAKE_W;

    localparam int WIN_W       = 16;
    localparam int LIMIT_W     = 8;
    localparam int STATUS_W    = 3;
    localparam int OCC_W       = 5;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 40;

    localparam logic [WIN_W-1:0]   WINDOW_RESET = 16'd1000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 8'd10;
    localparam logic [WIN_W-1:0]   ELAPSED_MAX  = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_ENQUEUE = 2'd1,
        OP_DEQUEUE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED       = 3'd0,
        ST_DROP_FULL    = 3'd1,
        ST_DROP_RATE    = 3'd2,
        ST_DELIVERED    = 3'd3,
        ST_NONE_DELIVER = 3'd4
    } status_t;

    typedef enum logic {
        CFG_WINDOW_LEN = 1'b0,
        CFG_MAX_EVENTS = 1'b1
    } cfg_index_t;

    typedef enum logic {
        S_IDLE    = 1'b0,
        S_DRAIN   = 1'b1
    } state_t;

endpackage
`default_nettype wire

@@ design/rate_limited_event_fifo.sv @@
// Top level of the rate-limited event FIFO: control, window counters and output register.
// Idle handles ticks and enqueues; an enqueue's result is valid the cycle after its transfer.
// A dequeue that delivers nothing answers from idle. Otherwise it moves to the drain state,
// which delivers one event each time the output register is free, through that register.
// Input waits while a dequeue drains or while the output register holds a result not taken.
// Reset (rst_n low, async) empties the queue, closes the window, restores 1000 and 10.
`default_nettype none
module rate_limited_event_fifo (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Input items.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [rlef_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // event_word[31:0], max_take[36:32]
    input  wire logic [1:0]                       s_axis_tuser,  // operation[1:0]
    // Result items.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [rlef_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // event_out[31:0], occupancy[36:32]
    output logic      [rlef_pkg::STATUS_W-1:0]    m_axis_tuser,  // status[2:0]
    output logic                                  m_axis_tlast,
    // Configuration writes.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic                             cfg_index,
    input  wire logic [15:0]                      cfg_data
);
    import rlef_pkg::*;

    state_t                  state_reg, state_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]        held_reg, held_next;
    logic                    win_open_reg, win_open_next;
    logic [WIN_W-1:0]        elapsed_reg, elapsed_next;
    logic [LIMIT_W-1:0]      admitted_reg, admitted_next;
    logic [TAKE_W-1:0]       remain_reg, remain_next;
    logic [WIN_W-1:0]        win_len_reg;
    logic [LIMIT_W-1:0]      limit_reg;

    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [EVENT_WIDTH-1:0]  out_event_reg, out_event_next;
    logic                    out_last_reg, out_last_next;
    logic [OCC_W-1:0]        out_occ_reg, out_occ_next;

    logic                    in_xfer;
    logic                    out_free;
    logic                    ram_we;
    logic [EVENT_WIDTH-1:0]  ram_rdata;

    logic [EVENT_WIDTH-1:0]  in_event;
    logic [TAKE_W-1:0]       in_take;
    logic [TAKE_W-1:0]       take_clamp;
    logic                    win_restart;
    logic [LIMIT_W-1:0]      admitted_eff;

    assign in_event   = s_axis_tdata[EVENT_WIDTH-1:0];
    assign in_take    = s_axis_tdata[EVENT_WIDTH +: TAKE_W];
    assign take_clamp = (in_take > TAKE_W'(MAX_TAKE)) ? TAKE_W'(MAX_TAKE) : in_take;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign win_restart  = !win_open_reg || (elapsed_reg >= win_len_reg);
    assign admitted_eff = win_restart ? '0 : admitted_reg;

    // The read port always follows the next read pointer, so its data is the oldest event.
    rlef_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EVENT_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (in_event),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        held_next       = held_reg;
        win_open_next   = win_open_reg;
        elapsed_next    = elapsed_reg;
        admitted_next   = admitted_reg;
        remain_next     = remain_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_event_next  = out_event_reg;
        out_last_next   = out_last_reg;
        out_occ_next    = out_occ_reg;
        ram_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (s_axis_tuser)
                        OP_TICK:
                        begin
                            if (win_open_reg && (elapsed_reg != ELAPSED_MAX))
                            begin
                                elapsed_next = elapsed_reg + 1'b1;
                            end
                        end
                        OP_ENQUEUE:
                        begin
                            out_valid_next = 1'b1;
                            out_event_next = '0;
                            out_last_next  = 1'b1;
                            out_occ_next   = OCC_W'(held_reg);
                            if (held_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                out_status_next = ST_DROP_FULL;
                            end
                            else
                            begin
                                if (win_restart)
                                begin
                                    win_open_next = 1'b1;
                                    elapsed_next  = '0;
                                    admitted_next = '0;
                                end
                                if (admitted_eff >= limit_reg)
                                begin
                                    out_status_next = ST_DROP_RATE;
                                end
                                else
                                begin
                                    admitted_next   = admitted_eff + 1'b1;
                                    ram_we          = 1'b1;
                                    wr_ptr_next     = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1))
                                                      ? '0 : wr_ptr_reg + 1'b1;
                                    held_next       = held_reg + 1'b1;
                                    out_status_next = ST_STORED;
                                    out_occ_next    = OCC_W'(held_reg + 1'b1);
                                end
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if ((take_clamp == '0) || (held_reg == '0))
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_NONE_DELIVER;
                                out_event_next  = '0;
                                out_last_next   = 1'b1;
                                out_occ_next    = OCC_W'(held_reg);
                            end
                            else
                            begin
                                state_next  = S_DRAIN;
                                remain_next = (CMP_W'(held_reg) < CMP_W'(take_clamp))
                                              ? TAKE_W'(held_reg) : take_clamp;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_DELIVERED;
                    out_event_next  = ram_rdata;
                    out_last_next   = (remain_reg == TAKE_W'(1));
                    out_occ_next    = OCC_W'(held_reg - 1'b1);
                    held_next       = held_reg - 1'b1;
                    rd_ptr_next     = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1))
                                      ? '0 : rd_ptr_reg + 1'b1;
                    remain_next     = remain_reg - 1'b1;
                    if (remain_reg == TAKE_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            held_reg      <= '0;
            win_open_reg  <= 1'b0;
            elapsed_reg   <= '0;
            admitted_reg  <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            held_reg      <= held_next;
            win_open_reg  <= win_open_next;
            elapsed_reg   <= elapsed_next;
            admitted_reg  <= admitted_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_event_reg  <= out_event_next;
        out_last_reg   <= out_last_next;
        out_occ_reg    <= out_occ_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= WINDOW_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WINDOW_LEN: win_len_reg <= cfg_data;
                CFG_MAX_EVENTS: limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - EVENT_WIDTH - OCC_W){1'b0}}, out_occ_reg, out_event_reg};

    // The queue never holds more events than it has entries.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("held count above queue depth");

    // A drain only runs with events left to deliver.
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> ((held_reg != '0) && (remain_reg != '0)))
        else $error("drain running on an empty queue");

    // Every accepted enqueue leaves a result in the output register.
    a_enqueue_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (s_axis_tuser == OP_ENQUEUE)) |=> (out_valid_reg && out_last_reg))
        else $error("enqueue produced no result");

    // The final delivery of a drain returns control to idle.
    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DRAIN) && out_free && (remain_reg == TAKE_W'(1)))
        |=> (state_reg == S_IDLE))
        else $error("drain did not end after last delivery");

endmodule
`default_nettype wire

@@ design/rlef_ram.sv @@
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none
module rlef_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ sim/rate_limited_event_fifo_test.sv @@
// Self-checking testbench for the rate-limited event FIFO with a predicting scoreboard.
module rate_limited_event_fifo_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rlef_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        status_t                status;
        logic [EVENT_WIDTH-1:0] event_word;
        logic                   last;
        logic [OCC_W-1:0]       occupancy;
    } fifo_result_t;

    class event_queue_tracker;
        fifo_result_t           awaited_results[$];
        logic [EVENT_WIDTH-1:0] held_events [QUEUE_DEPTH];
        logic [PTR_W-1:0]       head;
        logic [PTR_W-1:0]       tail;
        int                     held;
        bit                     window_open;
        logic [WIN_W-1:0]       elapsed_ms;
        logic [LIMIT_W-1:0]     admitted;
        logic [WIN_W-1:0]       window_len;
        logic [LIMIT_W-1:0]     event_limit;
        int                     errors;
        int                     items;
        int                     results;
        int                     status_seen [5];

        function new();
            head        = '0;
            tail        = '0;
            held        = 0;
            window_open = 1'b0;
            elapsed_ms  = '0;
            admitted    = '0;
            window_len  = WINDOW_RESET;
            event_limit = LIMIT_RESET;
            errors      = 0;
            items       = 0;
            results     = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [15:0] value);
            if (idx == CFG_WINDOW_LEN)
                window_len = value;
            else
                event_limit = value[LIMIT_W-1:0];
        endfunction

        function void queue_result(status_t st, logic [EVENT_WIDTH-1:0] word, logic last);
            fifo_result_t r;
            r.status     = st;
            r.event_word = word;
            r.last       = last;
            r.occupancy  = OCC_W'(held);
            awaited_results.push_back(r);
        endfunction

        // Called for every input transfer; works out the results it causes.
        function void accept_item(logic [1:0] op, logic [EVENT_WIDTH-1:0] word,
                                  logic [TAKE_W-1:0] take_field);
            int take;
            int n;
            items++;
            if (op == OP_TICK) begin
                if (window_open && elapsed_ms != ELAPSED_MAX)
                    elapsed_ms++;
            end
            else if (op == OP_ENQUEUE) begin
                // A full queue drops the event before the window is looked at.
                if (held >= QUEUE_DEPTH)
                    queue_result(ST_DROP_FULL, '0, 1'b1);
                else begin
                    if (!window_open || elapsed_ms >= window_len) begin
                        window_open = 1'b1;
                        elapsed_ms  = '0;
                        admitted    = '0;
                    end
                    if (admitted >= event_limit)
                        queue_result(ST_DROP_RATE, '0, 1'b1);
                    else begin
                        admitted++;
                        held_events[tail] = word;
                        tail++;
                        held++;
                        queue_result(ST_STORED, '0, 1'b1);
                    end
                end
            end
            else if (op == OP_DEQUEUE) begin
                take = (take_field > MAX_TAKE) ? MAX_TAKE : int'(take_field);
                n = 0;
                while (n < take && held > 0) begin
                    held--;
                    queue_result(ST_DELIVERED, held_events[head], (n == take - 1) || (held == 0));
                    head++;
                    n++;
                end
                if (n == 0)
                    queue_result(ST_NONE_DELIVER, '0, 1'b1);
            end
        endfunction

        function void flag_mismatch(string field, logic [EVENT_WIDTH-1:0] want,
                                    logic [EVENT_WIDTH-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [EVENT_WIDTH-1:0] word,
                                   logic last, logic [OCC_W-1:0] occupancy);
            fifo_result_t want;
            results++;
            if (awaited_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h %h %b %h",
                         $time, status, word, last, occupancy);
                return;
            end
            want = awaited_results.pop_front();
            status_seen[int'(want.status)]++;
            if (status !== want.status)
                flag_mismatch("status", EVENT_WIDTH'(want.status), EVENT_WIDTH'(status));
            if (word !== want.event_word)
                flag_mismatch("event_out", want.event_word, word);
            if (last !== want.last)
                flag_mismatch("last_of_run", EVENT_WIDTH'(want.last), EVENT_WIDTH'(last));
            if (occupancy !== want.occupancy)
                flag_mismatch("occupancy", EVENT_WIDTH'(want.occupancy), EVENT_WIDTH'(occupancy));
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n         = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata  = '0;
    logic [1:0]               s_axis_tuser  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]    m_axis_tdata;
    logic [STATUS_W-1:0]      m_axis_tuser;
    logic                     m_axis_tlast;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    cfg_index_t               cfg_index     = CFG_WINDOW_LEN;
    logic [15:0]              cfg_data      = '0;

    event_queue_tracker tracker = new();
    int                 sink_hold = 0;
    bit                 steady    = 1'b0;

    rate_limited_event_fifo u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("%0t: timeout with %0d results still awaited", $time,
                 tracker.awaited_results.size());
        $display("rate_limited_event_fifo_test: done, errors");
        $finish;
    end

    // Result side: checks every transfer, then decides the next cycle's ready.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tlast,
                                     m_axis_tdata[36:32]);
            if (!rst_n)
                m_axis_tready <= 1'b0;
            else if (sink_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold--;
            end
            else
                m_axis_tready <= steady || ($urandom_range(99) >= 36);
        end
    end

    task automatic send_item(logic [1:0] op, logic [EVENT_WIDTH-1:0] word,
                             logic [TAKE_W-1:0] take);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, take, word};
        do @(posedge clk); while (!s_axis_tready);
        tracker.accept_item(op, word, take);
        if (!steady && $urandom_range(99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 36);
        end
    endtask

    task automatic write_register(cfg_index_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Ticks leave no result behind, so a short pause follows the last result.
    task automatic wait_until_quiet();
        s_axis_tvalid <= 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random(int count, int tick_pct);
        int         sent;
        int         roll;
        int         burst;
        logic [1:0] op;
        logic [4:0] take;
        sent = 0;
        while (sent < count)
        begin
            roll = $urandom_range(99);
            take = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17))
                                            : 5'($urandom_range(16));
            if (roll < 8)
            begin
                // A burst of enqueues pushes the queue toward its limits.
                burst = $urandom_range(17, 4);
                repeat (burst) send_item(OP_ENQUEUE, $urandom, 5'($urandom));
                sent += burst;
                continue;
            end
            if (roll < 8 + tick_pct)
                op = OP_TICK;
            else if (roll < 60)
                op = OP_ENQUEUE;
            else if (roll < 95)
                op = OP_DEQUEUE;
            else
                op = OP_UNUSED;
            send_item(op, $urandom, take);
            if (op != OP_UNUSED)
                sent++;
        end
    endtask

    initial
    begin
        int k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: empty dequeue, unused code, a tick with no window open,
        // payload extremes, zero and oversized takes, then a rate drop.
        send_item(OP_DEQUEUE, 32'h1234_5678, 5'd5);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 5'd31);
        send_item(OP_TICK, 32'h0000_0000, 5'd0);
        send_item(OP_ENQUEUE, 32'h0000_0000, 5'd31);
        send_item(OP_ENQUEUE, 32'hFFFF_FFFF, 5'd0);
        send_item(OP_ENQUEUE, 32'hA5A5_5A5A, 5'd16);
        send_item(OP_DEQUEUE, 32'hFFFF_FFFF, 5'd0);
        send_item(OP_DEQUEUE, 32'h0000_0000, 5'd1);
        send_item(OP_DEQUEUE, 32'h0000_0000, 5'd31);
        for (k = 0; k < 8; k++)
            send_item(OP_ENQUEUE, $urandom, 5'($urandom));
        send_item(OP_DEQUEUE, 32'h0000_0000, 5'd16);
        wait_until_quiet();

        // Short windows with a small limit.
        write_register(CFG_WINDOW_LEN, 16'd3);
        write_register(CFG_MAX_EVENTS, 16'd4);
        send_random(20, 27);
        wait_until_quiet();

        // Zero window length and the highest limit: fill up to a full drop, then
        // hold off the result side while input keeps coming.
        write_register(CFG_WINDOW_LEN, 16'd0);
        write_register(CFG_MAX_EVENTS, 16'hA5FF);
        steady = 1'b1;
        for (k = 0; k < 17; k++)
            send_item(OP_ENQUEUE, $urandom, 5'($urandom));
        steady = 1'b0;
        sink_hold = 150;
        send_item(OP_DEQUEUE, $urandom, 5'd20);
        send_random(28, 10);
        wait_until_quiet();

        // Longest window with a zero limit: only drops.
        write_register(CFG_WINDOW_LEN, 16'hFFFF);
        write_register(CFG_MAX_EVENTS, 16'd0);
        send_random(18, 20);
        wait_until_quiet();

        // The window expires on the tick that brings its count to the window length.
        write_register(CFG_WINDOW_LEN, 16'd5);
        write_register(CFG_MAX_EVENTS, 16'd1);
        send_item(OP_DEQUEUE, $urandom, 5'd16);
        send_item(OP_DEQUEUE, $urandom, 5'd16);
        steady = 1'b1;
        repeat (5) send_item(OP_TICK, $urandom, 5'($urandom));
        send_item(OP_ENQUEUE, $urandom, 5'd0);
        send_item(OP_ENQUEUE, $urandom, 5'd0);
        repeat (4) send_item(OP_TICK, $urandom, 5'($urandom));
        send_item(OP_ENQUEUE, $urandom, 5'd0);
        send_item(OP_TICK, $urandom, 5'($urandom));
        steady = 1'b0;
        send_item(OP_ENQUEUE, $urandom, 5'd0);
        send_item(OP_DEQUEUE, $urandom, 5'd31);
        wait_until_quiet();

        // One-tick windows, first with both sides running freely.
        write_register(CFG_WINDOW_LEN, 16'd1);
        write_register(CFG_MAX_EVENTS, 16'd3);
        steady = 1'b1;
        send_random(12, 30);
        steady = 1'b0;
        send_random(12, 30);
        wait_until_quiet();

        write_register(CFG_WINDOW_LEN, 16'($urandom_range(12, 2)));
        write_register(CFG_MAX_EVENTS, 16'($urandom_range(20, 5)));
        send_random(15, 25);

        s_axis_tvalid <= 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d input transfers under seven register settings, with a long result stall.",
                 tracker.items);
        $display("Checked %0d results: %0d stored, %0d full, %0d rate, %0d delivered, %0d empty.",
                 tracker.results, tracker.status_seen[ST_STORED],
                 tracker.status_seen[ST_DROP_FULL], tracker.status_seen[ST_DROP_RATE],
                 tracker.status_seen[ST_DELIVERED], tracker.status_seen[ST_NONE_DELIVER]);
        if (tracker.errors == 0)
            $display("rate_limited_event_fifo_test: done, clean");
        else
            $display("rate_limited_event_fifo_test: done, errors");
        $finish;
    end

endmodule

@@ rate_limited_event_fifo.f @@
design/rlef_pkg.sv
design/rlef_ram.sv
design/rate_limited_event_fifo.sv
sim/rate_limited_event_fifo_test.sv
